// File: sv/kisco_pkg.sv
package kisco_pkg;

  localparam logic [23:0] ONE_Q20   = 24'h100000;
  localparam logic [23:0] THREE_Q20 = 24'h300000;
  localparam logic [23:0] NINE_Q20  = 24'h900000;
  localparam logic [30:0] ONE_Q30   = 31'h40000000;
  localparam logic [51:0] DIV_NUM   = 52'h8000000000000;

  localparam logic [16:0] EFF_HIGH  = 17'd32768;
  localparam logic [15:0] EFF_RESET = 16'd6554;

  localparam logic REG_FIXED_MODE = 1'b0;
  localparam logic REG_CONST_EFF  = 1'b1;

endpackage

// File: sv/kisco_root_cell.sv
module kisco_root_cell #(
  parameter int ORDER = 2,
  parameter int XW = 44,
  parameter int YW = 22,
  parameter int S = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [XW-1:0] x_in,
  input  logic [YW-1:0] y_in,
  output logic [XW-1:0] x_out,
  output logic [YW-1:0] y_out
);

  localparam int BW = XW + 2;

  logic [YW-1:0] y2;
  logic [BW-1:0] b;
  logic [XW-1:0] xs;
  logic [XW-1:0] bs;
  logic          take;

  assign y2 = {y_in[YW-2:0], 1'b0};

  generate
    if (ORDER == 3) begin : g_cube
      logic [YW:0]   y2p1;
      logic [2*YW:0] p;
      assign y2p1 = {1'b0, y2} + 1'b1;
      assign p    = y2 * y2p1;
      assign b    = BW'({p, 1'b0}) + BW'(p) + BW'(1);
    end else begin : g_square
      assign b = BW'({y2, 1'b1});
    end
  endgenerate

  assign xs   = x_in >> S;
  assign take = BW'(xs) >= b;
  assign bs   = XW'(b) << S;

  always_ff @(posedge clk) begin
    if (en) begin
      x_out <= take ? x_in - bs : x_in;
      y_out <= y2 + YW'(take);
    end
  end

endmodule

// File: sv/kisco_root_chain.sv
module kisco_root_chain #(
  parameter int ORDER = 2,
  parameter int LANES = 1,
  parameter int N = 22,
  parameter int XW = 44,
  parameter int SW = 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      vld_in,
  input  logic [LANES-1:0][XW-1:0]  x_in,
  input  logic [SW-1:0]             side_in,
  output logic                      vld_out,
  output logic [LANES-1:0][N-1:0]   root,
  output logic [SW-1:0]             side_out
);

  logic [N:0][LANES-1:0][XW-1:0] xs;
  logic [N:0][LANES-1:0][N-1:0]  ys;
  logic [N-1:0]                  vld;
  logic [N-1:0][SW-1:0]          side;

  assign xs[0] = x_in;
  assign ys[0] = '0;

  generate
    for (genvar k = 0; k < N; k++) begin : g_step
      for (genvar l = 0; l < LANES; l++) begin : g_lane
        kisco_root_cell #(
          .ORDER(ORDER),
          .XW(XW),
          .YW(N),
          .S(ORDER * (N - 1 - k))
        ) u_cell (
          .clk(clk),
          .en(en),
          .x_in(xs[k][l]),
          .y_in(ys[k][l]),
          .x_out(xs[k+1][l]),
          .y_out(ys[k+1][l])
        );
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[N-2:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side_in;
      for (int k = 1; k < N; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  assign vld_out  = vld[N-1];
  assign root     = ys[N];
  assign side_out = side[N-1];

endmodule

// File: sv/kisco_div_cell.sv
module kisco_div_cell #(
  parameter int RW = 52,
  parameter int DW = 25,
  parameter int N = 30,
  parameter int K = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [RW-1:0] rem_in,
  input  logic [DW-1:0] d_in,
  input  logic [N-1:0]  q_in,
  output logic [RW-1:0] rem_out,
  output logic [DW-1:0] d_out,
  output logic [N-1:0]  q_out
);

  logic [RW-1:0] rs;
  logic [RW-1:0] ds;
  logic          take;
  logic [N-1:0]  q_next;

  assign rs   = rem_in >> K;
  assign take = rs >= RW'(d_in);
  assign ds   = RW'(d_in) << K;

  always_comb begin
    q_next    = q_in;
    q_next[K] = take;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= take ? rem_in - ds : rem_in;
      d_out   <= d_in;
      q_out   <= q_next;
    end
  end

endmodule

// File: sv/kisco_div_chain.sv
module kisco_div_chain #(
  parameter int N = 30,
  parameter int RW = 52,
  parameter int DW = 25,
  parameter int SW = 24
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vld_in,
  input  logic [RW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side_in,
  output logic          vld_out,
  output logic [N-1:0]  quo,
  output logic [SW-1:0] side_out
);

  logic [N:0][RW-1:0] rs;
  logic [N:0][DW-1:0] ds;
  logic [N:0][N-1:0]  qs;
  logic [N-1:0]       vld;
  logic [N-1:0][SW-1:0] side;

  assign rs[0] = num;
  assign ds[0] = den;
  assign qs[0] = '0;

  generate
    for (genvar k = 0; k < N; k++) begin : g_step
      kisco_div_cell #(
        .RW(RW),
        .DW(DW),
        .N(N),
        .K(N - 1 - k)
      ) u_cell (
        .clk(clk),
        .en(en),
        .rem_in(rs[k]),
        .d_in(ds[k]),
        .q_in(qs[k]),
        .rem_out(rs[k+1]),
        .d_out(ds[k+1]),
        .q_out(qs[k+1])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[N-2:0], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= side_in;
      for (int k = 1; k < N; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  assign vld_out  = vld[N-1];
  assign quo      = qs[N];
  assign side_out = side[N-1];

endmodule

// File: sv/kerr_isco_radiative_efficiency.sv
// Last stable orbit radius and radiative efficiency of a spinning black hole.
// Input channel: spin_value (signed Q1.15) with spin_valid / spin_stall.
// Output channel: efficiency (Q0.16) and orbit_radius (Q4.12) with
// result_valid / result_stall.
// Configuration: write fixed_efficiency_mode (index 0) and constant_efficiency
// (index 1) through cfg_write / cfg_index / cfg_data while the block is idle.
// Every item passes through a fixed pipeline of 133 register stages: the
// digit chains of the three cube roots (21 cells), the two square roots of
// the orbit (22 and 23 cells), the divider (30 cells) and the efficiency
// square root (30 cells), plus seven arithmetic stages. One item is accepted
// every cycle while result_stall does not hold a waiting result.
// When result_stall holds a waiting result, the whole pipeline holds and
// spin_stall rises; it drops in the cycle the result is taken.
// Synchronous reset empties the pipeline and sets fixed mode off and the
// constant efficiency to 6554.
module kerr_isco_radiative_efficiency (
  input  logic        clk,
  input  logic        rst,
  input  logic        spin_valid,
  output logic        spin_stall,
  input  logic [15:0] spin_value,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [15:0] efficiency,
  output logic [15:0] orbit_radius,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic        fixed_mode;
  logic [15:0] const_eff;
  logic        adv;

  logic        a_vld;
  logic        a_retro;
  logic [15:0] a_amag;
  logic [30:0] a_a2;
  logic [15:0] amag;

  logic [2:0][62:0] cb_x;
  logic [2:0][20:0] cb_root;
  logic             cb_vld;
  logic [31:0]      cb_side;

  logic        m1_vld;
  logic        m1_retro;
  logic [21:0] m1_z1;
  logic [30:0] m1_a2;
  logic [21:0] csum;
  logic [42:0] cprod;

  logic        m2_vld;
  logic        m2_retro;
  logic [21:0] m2_z1;
  logic [43:0] m2_arg;
  logic [43:0] z1sq;

  logic        z2_vld;
  logic [21:0] z2;
  logic [22:0] z2_side;

  logic        m3_vld;
  logic        m3_retro;
  logic [22:0] m3_u;
  logic [45:0] m3_arg;
  logic [21:0] t1;
  logic [23:0] t2;

  logic        rt_vld;
  logic [22:0] rt;
  logic [23:0] rt_side;

  logic        m4_vld;
  logic [23:0] m4_r;
  logic [24:0] m4_d;
  logic [24:0] r_raw;
  logic [23:0] r_sat;

  logic        dv_vld;
  logic [29:0] dv_q;
  logic [23:0] dv_r;

  logic        m5_vld;
  logic [29:0] m5_t;
  logic [23:0] m5_r;

  logic        sq_vld;
  logic [29:0] sq_s;
  logic [23:0] sq_r;
  logic [30:0] effs;
  logic [30:0] eff_rnd;
  logic [16:0] eff17;
  logic [15:0] eff16;
  logic [24:0] rad_rnd;

  assign adv        = !result_valid || !result_stall;
  assign spin_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_mode <= 1'b0;
      const_eff  <= kisco_pkg::EFF_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        kisco_pkg::REG_FIXED_MODE: fixed_mode <= cfg_data[0];
        kisco_pkg::REG_CONST_EFF:  const_eff  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign amag = spin_value[15] ? 16'(-spin_value) : spin_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (adv) begin
      a_vld <= spin_valid && !spin_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_retro <= spin_value[15];
      a_amag  <= amag;
      a_a2    <= {15'd0, amag} * {15'd0, amag};
    end
  end

  assign cb_x[0] = 63'(kisco_pkg::ONE_Q30 - a_a2) << 30;
  assign cb_x[1] = 63'(17'(17'd32768 + 17'(a_amag))) << 45;
  assign cb_x[2] = 63'(16'(16'd32768 - a_amag)) << 45;

  kisco_root_chain #(
    .ORDER(3), .LANES(3), .N(21), .XW(63), .SW(32)
  ) u_cbrt (
    .clk(clk), .rst(rst), .en(adv),
    .vld_in(a_vld), .x_in(cb_x), .side_in({a_retro, a_a2}),
    .vld_out(cb_vld), .root(cb_root), .side_out(cb_side)
  );

  assign csum  = 22'(cb_root[1]) + 22'(cb_root[2]);
  assign cprod = cb_root[0] * csum;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
    end else if (adv) begin
      m1_vld <= cb_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_z1    <= 22'(kisco_pkg::ONE_Q20 + 24'(cprod >> 20));
      m1_a2    <= cb_side[30:0];
      m1_retro <= cb_side[31];
    end
  end

  assign z1sq = m1_z1 * m1_z1;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_vld <= 1'b0;
    end else if (adv) begin
      m2_vld <= m1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m2_arg   <= z1sq + 44'({m1_a2, 11'b0}) + 44'({m1_a2, 10'b0});
      m2_z1    <= m1_z1;
      m2_retro <= m1_retro;
    end
  end

  kisco_root_chain #(
    .ORDER(2), .LANES(1), .N(22), .XW(44), .SW(23)
  ) u_sqrt_z2 (
    .clk(clk), .rst(rst), .en(adv),
    .vld_in(m2_vld), .x_in(m2_arg), .side_in({m2_retro, m2_z1}),
    .vld_out(z2_vld), .root(z2), .side_out(z2_side)
  );

  assign t1 = (24'(z2_side[21:0]) >= kisco_pkg::THREE_Q20) ? 22'd0 :
              22'(kisco_pkg::THREE_Q20 - 24'(z2_side[21:0]));
  assign t2 = kisco_pkg::THREE_Q20 + 24'(z2_side[21:0]) + 24'({z2, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      m3_vld <= 1'b0;
    end else if (adv) begin
      m3_vld <= z2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m3_arg   <= t1 * t2;
      m3_u     <= 23'(kisco_pkg::THREE_Q20 + 24'(z2));
      m3_retro <= z2_side[22];
    end
  end

  kisco_root_chain #(
    .ORDER(2), .LANES(1), .N(23), .XW(46), .SW(24)
  ) u_sqrt_rt (
    .clk(clk), .rst(rst), .en(adv),
    .vld_in(m3_vld), .x_in(m3_arg), .side_in({m3_retro, m3_u}),
    .vld_out(rt_vld), .root(rt), .side_out(rt_side)
  );

  always_comb begin
    if (rt_side[23]) begin
      r_raw = 25'(rt_side[22:0]) + 25'(rt);
    end else if (rt_side[22:0] >= rt) begin
      r_raw = 25'(rt_side[22:0] - rt);
    end else begin
      r_raw = 25'd0;
    end
    if (r_raw < 25'(kisco_pkg::ONE_Q20)) begin
      r_sat = kisco_pkg::ONE_Q20;
    end else if (r_raw > 25'(kisco_pkg::NINE_Q20)) begin
      r_sat = kisco_pkg::NINE_Q20;
    end else begin
      r_sat = r_raw[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m4_vld <= 1'b0;
    end else if (adv) begin
      m4_vld <= rt_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m4_r <= r_sat;
      m4_d <= 25'({r_sat, 1'b0}) + 25'(r_sat);
    end
  end

  kisco_div_chain #(
    .N(30), .RW(52), .DW(25), .SW(24)
  ) u_div (
    .clk(clk), .rst(rst), .en(adv),
    .vld_in(m4_vld), .num(kisco_pkg::DIV_NUM), .den(m4_d), .side_in(m4_r),
    .vld_out(dv_vld), .quo(dv_q), .side_out(dv_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m5_vld <= 1'b0;
    end else if (adv) begin
      m5_vld <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m5_t <= 30'(kisco_pkg::ONE_Q30 - 31'(dv_q));
      m5_r <= dv_r;
    end
  end

  kisco_root_chain #(
    .ORDER(2), .LANES(1), .N(30), .XW(60), .SW(24)
  ) u_sqrt_eff (
    .clk(clk), .rst(rst), .en(adv),
    .vld_in(m5_vld), .x_in({m5_t, 30'b0}), .side_in(m5_r),
    .vld_out(sq_vld), .root(sq_s), .side_out(sq_r)
  );

  assign effs    = kisco_pkg::ONE_Q30 - 31'(sq_s);
  assign eff_rnd = effs + 31'd8192;
  assign eff17   = 17'(eff_rnd >> 14);
  assign eff16   = (eff17 > kisco_pkg::EFF_HIGH) ? 16'(kisco_pkg::EFF_HIGH) : eff17[15:0];
  assign rad_rnd = 25'(sq_r) + 25'd128;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= sq_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      efficiency   <= fixed_mode ? const_eff : eff16;
      orbit_radius <= fixed_mode ? 16'd0 : rad_rnd[23:8];
    end
  end

endmodule
